>>> rtl/pstb_pkg.sv
// Package for the spanning tree builder: word types, field widths and the
// sequencer state type. No dependencies.
package pstb_pkg;

   // Fixed field widths of the request and response words
   localparam int NODE_FIELD_BITS = 6;
   localparam int COST_FIELD_BITS = 16;

   // Node count after reset
   localparam logic [NODE_FIELD_BITS-1:0] NODE_COUNT_RESET = 6'd63;

   // Request action codes
   localparam logic ACT_ADD_EDGE = 1'b0;
   localparam logic ACT_BUILD    = 1'b1;

   // Request word, fields in order
   typedef struct packed {
      logic                       action;
      logic [NODE_FIELD_BITS-1:0] first_node;
      logic [NODE_FIELD_BITS-1:0] second_node;
      logic [COST_FIELD_BITS-1:0] edge_cost;
      logic                       one_way;
   } req_type;

   // Response word, one per node other than the root node 1
   typedef struct packed {
      logic [NODE_FIELD_BITS-1:0] parent_node;
      logic [NODE_FIELD_BITS-1:0] child_node;
      logic [COST_FIELD_BITS-1:0] tree_edge_cost;
      logic                       reached;
      logic                       last;
   } rsp_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_WR1,
      ST_ADD_WR2,
      ST_RELAX,
      ST_RELAX_END,
      ST_PICK,
      ST_EMIT,
      ST_EMIT_END
   } state_type;

endpackage

>>> rtl/pstb_ram.sv
// Generic simple dual port RAM: one write port, one read port with a
// registered read. No dependencies.
module pstb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/prim_spanning_tree_builder_unit.sv
// Top level of the dense Prim spanning tree builder: edge weight RAM,
// per-node key RAM and the sequencer. Uses pstb_pkg and pstb_ram.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start & !busy
//   response  rsp_valid, rsp_data            one-cycle strobe, no stall
//   csr       csr_valid, csr_ready,          written when valid & ready
//             csr_node_count
//
// After reset a clearing pass marks every weight RAM entry empty while busy
// stays high. An add-edge word is a read-modify-write of the weight RAM, of
// both entries when stored both ways. A build over n nodes runs up to n-1
// relax passes, each reading one weight row entry per cycle on the weight RAM
// read port, then gives one response word per node 2..n, the last one while
// busy is already low; a disconnected graph ends early. Responses come one per
// cycle and cannot be held off; csr_ready is always high.
module prim_spanning_tree_builder_unit #(
   parameter int MAX_NODES   = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  pstb_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output pstb_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pstb_pkg::NODE_FIELD_BITS-1:0]  csr_node_count
);

   import pstb_pkg::*;

   localparam int NB       = $clog2(MAX_NODES);
   localparam int WROW     = WEIGHT_BITS + 1;
   localparam int NROW     = WEIGHT_BITS + NB;
   localparam int WDEPTH   = 1 << (2 * NB);

   // Data stage tag: what the RAM read data returning this cycle belongs to
   typedef struct packed {
      logic          relax;
      logic          emit;
      logic [NB-1:0] node;
   } pipe_type;

   state_type state_ff, state_in;

   logic [2*NB-1:0]        clear_addr_ff;
   logic [NODE_FIELD_BITS-1:0] csr_node_count_ff;
   logic [NB-1:0]          n_ff, u_ff, iter_ff, scan_ff;
   logic [NB-1:0]          add_a_ff, add_b_ff;
   logic [WEIGHT_BITS-1:0] add_w_ff;
   logic                   add_one_way_ff;
   logic [MAX_NODES-1:0]   key_valid_ff, in_tree_ff;
   logic                   min_found_ff;
   logic [WEIGHT_BITS-1:0] min_key_ff;
   logic [NB-1:0]          min_node_ff;
   pipe_type               pipe_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   // RAM ports
   logic                   w_we, w_re;
   logic [2*NB-1:0]        w_waddr, w_raddr;
   logic [WROW-1:0]        w_wdata, w_rdata;
   logic                   n_we, n_re;
   logic [NB-1:0]          n_waddr, n_raddr;
   logic [NROW-1:0]        n_wdata, n_rdata;

   // Request decode
   logic                   accept;
   logic                   add_in_range;
   logic [NB-1:0]          req_a, req_b;
   logic [NB-1:0]          n_calc;

   // Data stage
   logic                   add_upd;
   logic                   relax_upd;
   logic                   cand_valid;
   logic [WEIGHT_BITS-1:0] cand_key;
   logic                   better;
   logic [WEIGHT_BITS-1:0] row_w, node_key;
   logic [NB-1:0]          node_parent;
   logic                   row_valid;

   // Weight store: valid bit over weight, addressed {from, to}
   pstb_ram #(
      .WIDTH (WROW),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_en   (w_re),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   // Node store: best key over tree parent
   pstb_ram #(
      .WIDTH (NROW),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_en   (n_re),
      .rd_addr (n_raddr),
      .rd_data (n_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Request decode: node range and clamped node count
   assign add_in_range = (int'(req_data.first_node) < MAX_NODES) &&
                         (int'(req_data.second_node) < MAX_NODES);
   assign req_a  = NB'(req_data.first_node);
   assign req_b  = NB'(req_data.second_node);
   assign n_calc = (int'(csr_node_count_ff) >= MAX_NODES - 1) ?
                   NB'(MAX_NODES - 1) : NB'(csr_node_count_ff);

   // Data stage: RAM words returning this cycle
   always_comb begin
      row_valid   = w_rdata[WROW-1];
      row_w       = w_rdata[WEIGHT_BITS-1:0];
      node_key    = n_rdata[NROW-1:NB];
      node_parent = n_rdata[NB-1:0];

      // parallel edges keep the smaller weight
      add_upd = !row_valid || (add_w_ff < row_w);

      // lower a key only on a strictly smaller weight
      relax_upd = pipe_ff.relax && row_valid && !in_tree_ff[pipe_ff.node] &&
                  (!key_valid_ff[pipe_ff.node] || (row_w < node_key));
      cand_valid = pipe_ff.relax && !in_tree_ff[pipe_ff.node] &&
                   (key_valid_ff[pipe_ff.node] || relax_upd);
      cand_key   = relax_upd ? row_w : node_key;
      // ascending scan with strict compare picks the lowest index on ties
      better     = cand_valid && (!min_found_ff || (cand_key < min_key_ff));

      // response word
      rsp_in.child_node = NODE_FIELD_BITS'(pipe_ff.node);
      rsp_in.last       = (pipe_ff.node == n_ff);
      if (key_valid_ff[pipe_ff.node]) begin
         rsp_in.parent_node    = NODE_FIELD_BITS'(node_parent);
         rsp_in.tree_edge_cost = COST_FIELD_BITS'(node_key);
         rsp_in.reached        = 1'b1;
      end else begin
         rsp_in.parent_node    = '0;
         rsp_in.tree_edge_cost = '0;
         rsp_in.reached        = 1'b0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (&clear_addr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.action == ACT_ADD_EDGE) begin
                  if (add_in_range) state_in = ST_ADD_WR1;
               end else if (int'(n_calc) >= 2) begin
                  state_in = ST_RELAX;
               end
            end
         end
         ST_ADD_WR1: begin
            state_in = add_one_way_ff ? ST_IDLE : ST_ADD_WR2;
         end
         ST_ADD_WR2: begin
            state_in = ST_IDLE;
         end
         ST_RELAX: begin
            if (scan_ff == n_ff) state_in = ST_RELAX_END;
         end
         ST_RELAX_END: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            // stop on a disconnected graph or after n-1 relax passes
            if (!min_found_ff || (iter_ff == n_ff - NB'(1))) state_in = ST_EMIT;
            else state_in = ST_RELAX;
         end
         ST_EMIT: begin
            if (scan_ff == n_ff) state_in = ST_EMIT_END;
         end
         ST_EMIT_END: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // RAM control
   always_comb begin
      w_we    = 1'b0;
      w_waddr = clear_addr_ff;
      w_wdata = '0;
      w_re    = 1'b0;
      w_raddr = {u_ff, scan_ff};
      n_re    = 1'b0;
      n_raddr = scan_ff;
      n_we    = relax_upd;
      n_waddr = pipe_ff.node;
      n_wdata = {row_w, u_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            w_we = 1'b1;
         end
         ST_IDLE: begin
            w_re    = accept && (req_data.action == ACT_ADD_EDGE) && add_in_range;
            w_raddr = {req_a, req_b};
         end
         ST_ADD_WR1: begin
            // reverse read may hit the entry written now on a self loop;
            // the stale word yields the same final value
            w_we    = add_upd;
            w_waddr = {add_a_ff, add_b_ff};
            w_wdata = {1'b1, add_w_ff};
            w_re    = !add_one_way_ff;
            w_raddr = {add_b_ff, add_a_ff};
         end
         ST_ADD_WR2: begin
            w_we    = add_upd;
            w_waddr = {add_b_ff, add_a_ff};
            w_wdata = {1'b1, add_w_ff};
         end
         ST_RELAX: begin
            w_re = 1'b1;
            n_re = 1'b1;
         end
         ST_EMIT: begin
            n_re = 1'b1;
         end
         ST_RELAX_END, ST_PICK, ST_EMIT_END: begin
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clear_addr_ff     <= '0;
         csr_node_count_ff <= NODE_COUNT_RESET;
         pipe_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         min_found_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            csr_node_count_ff <= csr_node_count;
         end

         if (state_ff == ST_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + (2*NB)'(1);
         end

         // latch a request word
         if (accept) begin
            add_a_ff       <= req_a;
            add_b_ff       <= req_b;
            add_w_ff       <= WEIGHT_BITS'(req_data.edge_cost);
            add_one_way_ff <= req_data.one_way;
            if (req_data.action == ACT_BUILD) begin
               n_ff            <= n_calc;
               u_ff            <= NB'(1);
               iter_ff         <= '0;
               scan_ff         <= NB'(1);
               // only node 1 holds a key and sits in the tree
               key_valid_ff    <= MAX_NODES'(2);
               in_tree_ff      <= MAX_NODES'(2);
               min_found_ff    <= 1'b0;
            end
         end

         // scan counters
         if (state_ff == ST_RELAX || state_ff == ST_EMIT) begin
            scan_ff <= scan_ff + NB'(1);
         end
         if (state_ff == ST_RELAX_END) begin
            iter_ff <= iter_ff + NB'(1);
         end
         if (state_ff == ST_PICK) begin
            if (state_in == ST_RELAX) begin
               u_ff                    <= min_node_ff;
               in_tree_ff[min_node_ff] <= 1'b1;
               scan_ff                 <= NB'(1);
               min_found_ff            <= 1'b0;
            end else begin
               scan_ff <= NB'(2);
            end
         end

         // relax results and running minimum for the next pick
         if (relax_upd) begin
            key_valid_ff[pipe_ff.node] <= 1'b1;
         end
         if (better) begin
            min_found_ff <= 1'b1;
            min_key_ff   <= cand_key;
            min_node_ff  <= pipe_ff.node;
         end

         pipe_ff <= '{relax: (state_ff == ST_RELAX), emit: (state_ff == ST_EMIT),
                      node: scan_ff};

         rsp_valid_ff <= pipe_ff.emit;
      end
      rsp_ff <= rsp_in;
   end

   // Node RAM read-modify-write never reads the entry being written
   assert property (@(posedge clock) disable iff (reset)
      (n_we && n_re) |-> (n_waddr != n_raddr))
      else $error("node RAM read collides with write");

   // The node being relaxed is already in the tree
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX) |-> in_tree_ff[u_ff])
      else $error("relax node not in tree");

   // No data stage work is left once the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!pipe_ff.relax && !pipe_ff.emit))
      else $error("pipeline active while idle");

   // Responses run in consecutive child order and stop after last
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=>
         (rsp_valid && (rsp_data.child_node ==
            NODE_FIELD_BITS'($past(rsp_data.child_node) + 1'b1))))
      else $error("response sequence broken");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("response after last");

endmodule
